// File: rtl/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

  // Widths of the configuration register and of the item fields.
  localparam int CNT_W   = 11;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 10;

  // Input word layout: search_mode, entry_index, entry_value, search_key.
  localparam int IN_MODE_LSB  = 0;
  localparam int IN_IDX_LSB   = IN_MODE_LSB + MODE_W;
  localparam int IN_VAL_LSB   = IN_IDX_LSB + IDX_W;
  localparam int IN_KEY_LSB   = IN_VAL_LSB + VAL_W;
  localparam int IN_USED_W    = IN_KEY_LSB + VAL_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Result word layout: found, position.
  localparam int OUT_USED_W   = 1 + POS_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Item kinds carried on the input tuser bit.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Search modes.
  localparam logic [MODE_W-1:0] MODE_ANY_EQ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST_EQ = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LAST_EQ  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST_GE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LAST_LE  = 3'd4;

  // Control state of the search sequencer.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: rtl/sorted_table_bound_search.sv
// Load words give no result; loads can follow back to back.
// A search makes one table read per halving step plus one per neighbour read; a search over
// an empty table makes none, and an unknown mode ends at its first step with no match.
// The result word passes from S_DONE into the output register; the next word is taken once
// the sequencer is back in S_IDLE, and a waiting result stalls the next search in S_DONE.
// Reset (rst, synchronous) clears the control state and entries_in_use, not the table.
`default_nettype none

module sorted_table_bound_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration: entries_in_use.
  input  wire logic                   cfg_we,
  input  wire logic [CNT_W-1:0]       cfg_wdata,
  // Input words.
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // s_tdata, from bit 0: search_mode[2:0], entry_index[12:3],
  // entry_value[44:13], search_key[76:45], zero padding.
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: op (0 load, 1 search).
  input  wire logic                   s_tuser,
  // Result words.
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // m_tdata, from bit 0: found[0], position[10:1], zero padding.
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = (CNT_W > $clog2(TABLE_DEPTH + 1)) ? CNT_W : $clog2(TABLE_DEPTH + 1);
  localparam int IXW = ((IDX_W > AW) ? IDX_W : AW) + 1;
  localparam int PXW = (POS_W > AW) ? POS_W : AW;

  state_t                   state;
  logic                     nbr_phase;
  logic [CNT_W-1:0]         entries_in_use;
  logic [AW-1:0]            lo;
  logic [AW-1:0]            hi;
  logic [AW-1:0]            m;
  logic [AW-1:0]            last_idx;
  logic signed [VAL_W-1:0]  key;
  logic [MODE_W-1:0]        mode;
  logic                     res_found;
  logic [POS_W-1:0]         res_pos;
  logic                     out_found;
  logic [POS_W-1:0]         out_pos;

  // Field extraction from the input word.
  logic                     s_acc;
  logic [MODE_W-1:0]        in_mode;
  logic [IDX_W-1:0]         in_idx;
  logic [VAL_W-1:0]         in_val;
  logic [VAL_W-1:0]         in_key;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign in_mode  = s_tdata[IN_MODE_LSB +: MODE_W];
  assign in_idx   = s_tdata[IN_IDX_LSB +: IDX_W];
  assign in_val   = s_tdata[IN_VAL_LSB +: VAL_W];
  assign in_key   = s_tdata[IN_KEY_LSB +: VAL_W];

  // Table write path: loads beyond the table are dropped.
  logic [IXW-1:0]           idx_ext;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;

  assign idx_ext = IXW'(in_idx);
  assign wr_en   = s_acc && (s_tuser == OP_LOAD) && (idx_ext < IXW'(TABLE_DEPTH));
  assign wr_addr = idx_ext[AW-1:0];

  // Search span from the entry count, saturated to the table depth.
  logic [NW-1:0]            cnt_ext;
  logic [NW-1:0]            n_sat;
  logic [NW-1:0]            n_m1;
  logic                     n_zero;
  logic [AW-1:0]            first_last;

  assign cnt_ext    = NW'(entries_in_use);
  assign n_sat      = (cnt_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : cnt_ext;
  assign n_zero     = (n_sat == '0);
  assign n_m1       = n_sat - NW'(1);
  assign first_last = n_m1[AW-1:0];

  // Candidate next probes, prepared from registered bounds.
  logic [AW-1:0]            m_p1;
  logic [AW-1:0]            m_m1;
  logic [AW-1:0]            mid_up;
  logic [AW-1:0]            mid_dn;
  logic                     can_up;
  logic                     can_dn;

  assign m_p1   = m + AW'(1);
  assign m_m1   = m - AW'(1);
  assign mid_up = m_p1 + ((hi - m_p1) >> 1);
  assign mid_dn = lo + ((m_m1 - lo) >> 1);
  assign can_up = (m < hi);
  assign can_dn = (lo < m);

  // Table read data and the comparisons of one step.
  logic [VAL_W-1:0]         rd_data;
  logic signed [VAL_W-1:0]  rd_val;
  logic                     v_lt;
  logic                     v_gt;
  logic                     v_ne;

  assign rd_val = signed'(rd_data);
  assign v_lt   = (rd_val < key);
  assign v_gt   = (rd_val > key);
  assign v_ne   = (rd_val != key);

  // Decision of one step: hit, narrow up, narrow down or read a neighbour.
  logic go_up;
  logic go_dn;
  logic hit;
  logic miss;
  logic nbr_dn;
  logic nbr_up;

  always_comb begin
    go_up  = 1'b0;
    go_dn  = 1'b0;
    hit    = 1'b0;
    miss   = 1'b0;
    nbr_dn = 1'b0;
    nbr_up = 1'b0;
    if (!nbr_phase) begin
      case (mode)
        MODE_ANY_EQ: begin
          if (v_lt) go_up = 1'b1;
          else if (v_gt) go_dn = 1'b1;
          else hit = 1'b1;
        end
        MODE_FIRST_EQ: begin
          if (v_lt) go_up = 1'b1;
          else if (v_gt) go_dn = 1'b1;
          else if (m == '0) hit = 1'b1;
          else nbr_dn = 1'b1;
        end
        MODE_LAST_EQ: begin
          if (v_lt) go_up = 1'b1;
          else if (v_gt) go_dn = 1'b1;
          else if (m == last_idx) hit = 1'b1;
          else nbr_up = 1'b1;
        end
        MODE_FIRST_GE: begin
          if (v_lt) go_up = 1'b1;
          else if (m == '0) hit = 1'b1;
          else nbr_dn = 1'b1;
        end
        MODE_LAST_LE: begin
          if (v_gt) go_dn = 1'b1;
          else if (m == last_idx) hit = 1'b1;
          else nbr_up = 1'b1;
        end
        default: begin
          miss = 1'b1;
        end
      endcase
    end else begin
      case (mode)
        MODE_FIRST_EQ: begin
          if (v_ne) hit = 1'b1;
          else go_dn = 1'b1;
        end
        MODE_LAST_EQ: begin
          if (v_ne) hit = 1'b1;
          else go_up = 1'b1;
        end
        MODE_FIRST_GE: begin
          if (v_lt) hit = 1'b1;
          else go_dn = 1'b1;
        end
        MODE_LAST_LE: begin
          if (v_gt) hit = 1'b1;
          else go_up = 1'b1;
        end
        default: begin
          miss = 1'b1;
        end
      endcase
    end
  end

  logic take_up;
  logic take_dn;
  logic miss_all;

  assign take_up  = go_up && can_up;
  assign take_dn  = go_dn && can_dn;
  assign miss_all = miss || (go_up && !can_up) || (go_dn && !can_dn);

  // Read address: the next probe is issued in the same cycle as the decision.
  logic [AW-1:0] rd_addr;

  always_comb begin
    rd_addr = m;
    if (state == S_IDLE) begin
      rd_addr = first_last >> 1;
    end else if (take_up) begin
      rd_addr = mid_up;
    end else if (take_dn) begin
      rd_addr = mid_dn;
    end else if (nbr_dn) begin
      rd_addr = m_m1;
    end else if (nbr_up) begin
      rd_addr = m_p1;
    end
  end

  stbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_val),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Position of the current probe, cut to the result field.
  logic [PXW-1:0] m_ext;

  assign m_ext = PXW'(m);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      nbr_phase <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_acc && (s_tuser == OP_SEARCH)) begin
            if (n_zero) begin
              state <= S_DONE;
            end else begin
              state <= S_EVAL;
            end
            nbr_phase <= 1'b0;
          end
        end
        S_EVAL: begin
          if (hit || miss_all) begin
            state <= S_DONE;
          end else if (take_up || take_dn) begin
            nbr_phase <= 1'b0;
          end else if (nbr_dn || nbr_up) begin
            nbr_phase <= 1'b1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Search bounds, probe and result payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      lo        <= '0;
      hi        <= first_last;
      last_idx  <= first_last;
      m         <= first_last >> 1;
      key       <= signed'(in_key);
      mode      <= in_mode;
      res_found <= 1'b0;
      res_pos   <= '0;
    end else if (state == S_EVAL) begin
      if (hit) begin
        res_found <= 1'b1;
        res_pos   <= m_ext[POS_W-1:0];
      end else if (miss_all) begin
        res_found <= 1'b0;
        res_pos   <= '0;
      end else if (take_up) begin
        lo <= m_p1;
        m  <= mid_up;
      end else if (take_dn) begin
        hi <= m_m1;
        m  <= mid_dn;
      end
    end
  end

  // Output register: holds a finished word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      out_found <= res_found;
      out_pos   <= res_pos;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_pos, out_found};

  // The bounds never cross while a search is running.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (lo <= hi))
    else $error("search bounds crossed while searching");

  // The probe always lies within the current bounds.
  a_probe_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> ((m >= lo) && (m <= hi)))
    else $error("probe outside search bounds");

  // A search over an empty table finishes straight away.
  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (s_tuser == OP_SEARCH) && n_zero) |=> (state == S_DONE) && !res_found)
    else $error("empty table search did not finish at once");

  // A word reporting no match carries position zero.
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_found) |-> (out_pos == '0))
    else $error("miss reported with non-zero position");

endmodule

`default_nettype wire

// File: rtl/stbs_ram.sv
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_sorted_table_bound_search.sv
module tb_sorted_table_bound_search
  import stbs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = 1024;
  localparam int DIRECTED_WORDS = 23;
  localparam int RANDOM_WORDS   = 1350;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 40;
  localparam int COUNT_MAX      = (1 << CNT_W) - 1;
  localparam int MODE_TOP       = (1 << MODE_W) - 1;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One input word, unpacked into its fields.
  typedef struct {
    logic                     op;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  value;
    logic signed [VAL_W-1:0]  key;
  } word_t;

  // One search answer.
  typedef struct {
    logic              found;
    logic [POS_W-1:0]  position;
  } answer_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CNT_W-1:0]        cfg_wdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // s_tdata, from bit 0: search_mode, entry_index, entry_value, search_key, padding.
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  // s_tuser: op (load or search).
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  // m_tdata, from bit 0: found, position, padding.
  logic [OUT_TDATA_W-1:0]  m_tdata;

  // Stimulus side: words waiting to be sent and the table as planned.
  word_t                    pending_words[$];
  logic signed [VAL_W-1:0]  planned_entries [TABLE_DEPTH];
  int                       words_queued = 0;
  bit                       send_idle = 1'b1;
  bit                       recv_idle = 1'b1;
  int                       hold_requests = 0;

  // Prediction side: the table as accepted, the entry count and the answers due.
  logic signed [VAL_W-1:0]  shadow_entries [TABLE_DEPTH];
  int                       model_count = 0;
  answer_t                  expected_answers[$];

  int fail_count = 0;
  int results_seen = 0;

  sorted_table_bound_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_failure(string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endfunction

  // Halving search over the shadow table, mode by mode.
  function automatic answer_t search_shadow_table(logic [MODE_W-1:0] mode,
                                                  logic signed [VAL_W-1:0] key, int n);
    answer_t                  a;
    int                       lo;
    int                       hi;
    int                       mid;
    int                       hit;
    bit                       done;
    logic signed [VAL_W-1:0]  v;
    lo = 0;
    hi = n - 1;
    hit = -1;
    done = 1'b0;
    while (!done && lo <= hi) begin
      mid = lo + ((hi - lo) >> 1);
      v = shadow_entries[mid];
      case (mode)
        MODE_ANY_EQ: begin
          if (v < key) lo = mid + 1;
          else if (v > key) hi = mid - 1;
          else begin
            hit = mid;
            done = 1'b1;
          end
        end
        MODE_FIRST_EQ: begin
          if (v < key) lo = mid + 1;
          else if (v > key) hi = mid - 1;
          else if (mid == 0 || shadow_entries[mid-1] != key) begin
            hit = mid;
            done = 1'b1;
          end else hi = mid - 1;
        end
        MODE_LAST_EQ: begin
          if (v < key) lo = mid + 1;
          else if (v > key) hi = mid - 1;
          else if (mid == n - 1 || shadow_entries[mid+1] != key) begin
            hit = mid;
            done = 1'b1;
          end else lo = mid + 1;
        end
        MODE_FIRST_GE: begin
          if (v >= key) begin
            if (mid == 0 || shadow_entries[mid-1] < key) begin
              hit = mid;
              done = 1'b1;
            end else hi = mid - 1;
          end else lo = mid + 1;
        end
        MODE_LAST_LE: begin
          if (v <= key) begin
            if (mid == n - 1 || shadow_entries[mid+1] > key) begin
              hit = mid;
              done = 1'b1;
            end else lo = mid + 1;
          end else hi = mid - 1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    a.found = (hit >= 0);
    a.position = (hit >= 0) ? hit[POS_W-1:0] : '0;
    return a;
  endfunction

  // Apply one accepted word: a load updates the shadow table, a search owes an answer.
  function automatic void track_word(word_t w);
    int n;
    if (w.op == OP_LOAD) begin
      shadow_entries[w.idx] = w.value;
    end else begin
      n = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
      expected_answers.push_back(search_shadow_table(w.mode, w.key, n));
    end
  endfunction

  // Sender: one word on the bus at a time, with a drawn gap after each.
  word_t cur_word;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) track_word(cur_word);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur_word.op;
          s_tdata  <= IN_TDATA_W'({cur_word.key, cur_word.value, cur_word.idx, cur_word.mode});
          gap_left <= send_idle ? $urandom_range(0, 6) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Compare an accepted result with the oldest answer due.
  function automatic void check_answer(logic [OUT_TDATA_W-1:0] data);
    answer_t want;
    answer_t got;
    got.found = data[0];
    got.position = data[POS_W:1];
    if (expected_answers.size() == 0) begin
      note_failure($sformatf("result %0d arrived with no search pending: found %0b position %0d",
                             results_seen, got.found, got.position));
    end else begin
      want = expected_answers.pop_front();
      if (got.found !== want.found || got.position !== want.position) begin
        note_failure($sformatf({"result %0d: expected found %0b position %0d, ",
                                "got found %0b position %0d"},
                               results_seen, want.found, want.position, got.found,
                               got.position));
      end
    end
    results_seen++;
  endfunction

  // Receiver: short drawn stalls per word, and long hold-offs on request.
  int stall_left = 0;
  int hold_left = 0;
  int holds_served = 0;

  always @(posedge clk) begin
    int pause;
    if (rst) begin
      m_tready     <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else begin
      if (m_tvalid && m_tready) check_answer(m_tdata);
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES;
        m_tready     <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= (hold_left == 1);
      end else if (m_tvalid && m_tready) begin
        pause = recv_idle ? $urandom_range(0, 6) : 0;
        stall_left <= pause;
        m_tready   <= (pause == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= (stall_left == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_load(int idx, logic signed [VAL_W-1:0] value);
    word_t w;
    w.op    = OP_LOAD;
    w.mode  = MODE_W'($urandom_range(0, MODE_TOP));
    w.idx   = idx[IDX_W-1:0];
    w.value = value;
    w.key   = $urandom;
    planned_entries[idx] = value;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_search(int mode, logic signed [VAL_W-1:0] key);
    word_t w;
    w.op    = OP_SEARCH;
    w.mode  = mode[MODE_W-1:0];
    w.idx   = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    w.value = $urandom;
    w.key   = key;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Wait until every word has gone in and every answer has come out.
  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int value);
    settle();
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= value[CNT_W-1:0];
    model_count <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int effective_count();
    return (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
  endfunction

  // Mostly the five real modes, now and then an unknown one.
  function automatic int pick_mode();
    if ($urandom_range(0, 19) == 0) return $urandom_range(MODE_LAST_LE + 1, MODE_TOP);
    return $urandom_range(MODE_ANY_EQ, MODE_LAST_LE);
  endfunction

  // Keys near the table's contents hit the interesting paths; the rest are wild.
  function automatic logic signed [VAL_W-1:0] pick_key(int n);
    int                       c;
    logic signed [VAL_W-1:0]  v;
    c = $urandom_range(0, 9);
    if (n > 0 && c < 6) begin
      v = planned_entries[$urandom_range(0, n - 1)];
      if (c == 4) v = v + 1;
      if (c == 5) v = v - 1;
    end else if (c == 6) v = VAL_MIN;
    else if (c == 7) v = VAL_MAX;
    else v = $urandom;
    return v;
  endfunction

  // Ascending steps with plenty of duplicates, held at or below the top of the range.
  function automatic longint next_value(longint prev);
    int      c;
    longint  v;
    c = $urandom_range(0, 9);
    if (c < 3) v = prev;
    else if (c < 7) v = prev + $urandom_range(1, 3);
    else v = prev + $urandom_range(1, 1 << 21);
    if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
    return v;
  endfunction

  task automatic load_sorted_run(int n, longint start);
    longint                   v;
    bit                       backwards;
    logic signed [VAL_W-1:0]  run_vals [TABLE_DEPTH];
    v = start;
    backwards = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      v = next_value(v);
      run_vals[i] = v[VAL_W-1:0];
    end
    for (int i = 0; i < n; i++) begin
      if (backwards) queue_load(n - 1 - i, run_vals[n - 1 - i]);
      else queue_load(i, run_vals[i]);
    end
  endtask

  task automatic queue_searches(int count);
    for (int i = 0; i < count; i++) begin
      queue_search(pick_mode(), pick_key(effective_count()));
    end
  endtask

  // Once the backlog is down to searches, hold the output so that the block backs up.
  task automatic hold_output_when(int backlog);
    do @(negedge clk);
    while (pending_words.size() > backlog);
    hold_requests = hold_requests + 1;
  endtask

  task automatic draw_idling();
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
  endtask

  initial begin
    int n;
    int kind;
    int searches;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty table: nothing can be found.
    write_count(0);
    queue_search(MODE_ANY_EQ, 0);
    queue_search(MODE_LAST_LE, VAL_MAX);

    // One-entry table, every mode, keys on both sides, and the unknown modes.
    queue_load(0, -5);
    write_count(1);
    for (int m = MODE_ANY_EQ; m <= MODE_LAST_LE; m++) queue_search(m, -5);
    queue_search(MODE_FIRST_GE, VAL_MAX);
    queue_search(MODE_LAST_LE, VAL_MIN);
    for (int m = MODE_LAST_LE + 1; m <= MODE_TOP; m++) queue_search(m, -5);

    // Extreme values with a run of duplicates between them.
    queue_load(0, VAL_MIN);
    queue_load(1, 7);
    queue_load(2, 7);
    queue_load(3, VAL_MAX);
    write_count(4);
    queue_search(MODE_FIRST_EQ, 7);
    queue_search(MODE_LAST_EQ, 7);
    queue_search(MODE_FIRST_GE, 8);
    queue_search(MODE_LAST_LE, 6);

    // An unsorted table: the halving steps decide the answer.
    queue_load(1, 100);
    queue_search(MODE_ANY_EQ, 7);

    // Fill the whole table, search it, then search with a count beyond the depth.
    write_count(TABLE_DEPTH);
    draw_idling();
    load_sorted_run(TABLE_DEPTH, longint'(VAL_MIN) + $urandom_range(0, 1000));
    queue_searches(48);
    hold_output_when(40);
    write_count(COUNT_MAX);
    queue_searches(24);

    // Every entry is now written, so any count is safe from here on.
    while (words_queued < DIRECTED_WORDS + RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // A fresh sorted run at the bottom of the table, then searches over it.
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(25, 160);
        write_count(($urandom_range(0, 5) == 0) ? $urandom_range(0, COUNT_MAX) : n);
        draw_idling();
        load_sorted_run(n, longint'($signed($urandom)));
        searches = $urandom_range(n / 2 + 4, (n > 20) ? 48 : 2 * n + 8);
        queue_searches(searches);
        if ($urandom_range(0, 5) == 0) hold_output_when(searches / 2);
      end else if (kind < 8) begin
        // New count over whatever the table holds.
        case ($urandom_range(0, 4))
          0: n = 0;
          1: n = 1;
          2: n = TABLE_DEPTH;
          3: n = $urandom_range(TABLE_DEPTH + 1, COUNT_MAX);
          default: n = $urandom_range(2, TABLE_DEPTH - 1);
        endcase
        write_count(n);
        draw_idling();
        queue_searches($urandom_range(12, 30));
      end else begin
        // Stray loads anywhere mixed with searches.
        @(negedge clk);
        draw_idling();
        for (int i = 0; i < 20; i++) begin
          if ($urandom_range(0, 1) == 0) begin
            queue_load($urandom_range(0, TABLE_DEPTH - 1), $urandom);
          end else begin
            queue_search(pick_mode(), pick_key(effective_count()));
          end
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_answers.size() != 0) begin
      note_failure($sformatf("%0d answers never arrived", expected_answers.size()));
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
